// File: src/acelo_pkg.sv
// Shared types, constants and the arctangent table for the ellipse outline stepper.
package acelo_pkg;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MAIN = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;

	localparam int          CORDIC_STEPS = 30;
	localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	typedef struct packed {
		logic               begin_f;
		logic signed [10:0] center_x;
		logic signed [10:0] center_y;
		logic        [7:0]  rad_h;
		logic        [6:0]  rad_v_half;
		logic        [16:0] sweep;
	} cmd_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0:  r = 32'h20000000;
				5'd1:  r = 32'h12E4051D;
				5'd2:  r = 32'h09FB385B;
				5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43;
				5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E;
				5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53;
				5'd9:  r = 32'h00145F2E;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2F9;
				5'd15: r = 32'h0000517C;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A2F;
				5'd19: r = 32'h00000517;
				5'd20: r = 32'h0000028B;
				5'd21: r = 32'h00000145;
				5'd22: r = 32'h000000A2;
				5'd23: r = 32'h00000051;
				5'd24: r = 32'h00000028;
				5'd25: r = 32'h00000014;
				5'd26: r = 32'h0000000A;
				5'd27: r = 32'h00000005;
				5'd28: r = 32'h00000002;
				5'd29: r = 32'h00000001;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction

endpackage

// File: src/acelo_in_if.sv
// Input channel: command transfers into the ellipse outline stepper.
interface acelo_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [10:0] center_x;
	logic signed [10:0] center_y;
	logic        [7:0]  radius_x;
	logic        [7:0]  radius_y;
	logic        [16:0] sweep;

	modport source(output valid, action, center_x, center_y, radius_x, radius_y, sweep,
		input ready);
	modport sink(input valid, action, center_x, center_y, radius_x, radius_y, sweep,
		output ready);
endinterface

// File: src/acelo_out_if.sv
// Output channel: point transfers out of the ellipse outline stepper.
interface acelo_out_if;
	logic               valid;
	logic               ready;
	logic               drawn;
	logic signed [11:0] out_x;
	logic signed [12:0] out_y;
	logic               last;
	logic               finished;

	modport source(output valid, drawn, out_x, out_y, last, finished, input ready);
	modport sink(input valid, drawn, out_x, out_y, last, finished, output ready);
endinterface

// File: src/acelo_front.sv
// Front end: accepts commands, saturates radii and queues them for the walker.
module acelo_front #(
	parameter int MAX_RADIUS = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	acelo_in_if.sink          in_ch,
	output logic              cmd_valid,
	output acelo_pkg::cmd_t   cmd,
	input  logic              cmd_ready
);
	import acelo_pkg::*;

	localparam int RCAP = (MAX_RADIUS > 255) ? 255 : MAX_RADIUS;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [7:0] rx_sat, ry_sat;
	cmd_t       wr_cmd;
	logic       push, pop;

	assign rx_sat = (in_ch.radius_x > 8'(RCAP)) ? 8'(RCAP) : in_ch.radius_x;
	assign ry_sat = (in_ch.radius_y > 8'(RCAP)) ? 8'(RCAP) : in_ch.radius_y;

	always_comb begin
		wr_cmd.begin_f    = ~in_ch.action;
		wr_cmd.center_x   = in_ch.center_x;
		wr_cmd.center_y   = in_ch.center_y;
		wr_cmd.rad_h      = rx_sat;
		wr_cmd.rad_v_half = ry_sat[7:1];
		wr_cmd.sweep      = in_ch.sweep;
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign cmd_valid   = (cnt_q != 2'd0);
	assign pop         = cmd_valid && cmd_ready;
	assign cmd         = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// File: src/acelo_angle.sv
// Shared shift-and-add arctangent unit, two rotation steps per cycle, first octant.
module acelo_angle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] big,
	input  logic [15:0] small_in,
	output logic        done,
	output logic [31:0] z_oct
);
	import acelo_pkg::*;

	typedef struct packed {
		logic [41:0] x;
		logic [41:0] y;
		logic [31:0] z;
	} rot_t;

	function automatic rot_t rot_step(input rot_t s, input logic [4:0] i);
		logic [41:0] sx;
		rot_t        r;
		begin
			r  = s;
			sx = s.x >> i;
			if (s.y >= sx) begin
				r.y = s.y - sx;
				r.x = s.x + (s.y >> i);
				r.z = s.z + atan_turn(i);
			end
			return r;
		end
	endfunction

	rot_t       st_q, st1, st2;
	logic [4:0] i_q;
	logic       busy_q, done_q;

	assign st1 = rot_step(st_q, i_q);
	assign st2 = rot_step(st1, i_q + 5'd1);

	always_ff @(posedge clk) begin
		if (start) begin
			st_q.x <= {2'b0, big, 24'b0};
			st_q.y <= {2'b0, small_in, 24'b0};
			st_q.z <= 32'b0;
		end else if (busy_q) begin
			st_q <= st2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= 5'd0;
			end else if (busy_q) begin
				i_q <= i_q + 5'd2;
				if (i_q == 5'(CORDIC_STEPS - 2)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done  = done_q;
	assign z_oct = (st_q.z > EIGHTH_TURN) ? EIGHTH_TURN : st_q.z;
endmodule

// File: src/acelo_back.sv
// Back end: ellipse walk sequencer, angle test per point and output register.
module acelo_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  acelo_pkg::cmd_t cmd,
	output logic            cmd_ready,
	acelo_out_if.source     out_ch
);
	import acelo_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT1 = 3'd1;
	localparam logic [2:0] ST_INIT2 = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_CORD  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]         state_q;
	logic [1:0]         phase_q;
	logic signed [10:0] cen_x_q, cen_y_q;
	logic [7:0]         rh_q;
	logic [6:0]         rv_q;
	logic [16:0]        sweep_q;
	logic signed [8:0]  step_x_q;
	logic [7:0]         step_y_q;
	logic signed [39:0] inc_x_q, inc_y_q, err_q;
	logic [13:0]        rv2_q;
	logic [15:0]        rh2_q;
	logic signed [8:0]  px_q;
	logic [7:0]         py_q;
	logic               tail_q;
	logic [1:0]         k_q;
	logic [15:0]        u_q, v_q;
	logic               vgt_q;
	logic [31:0]        t_q;

	logic               ov_q, drawn_q, last_q, fin_q;
	logic signed [11:0] ox_q;
	logic signed [12:0] oy_q;

	logic               slot_free, out_fire;
	logic signed [39:0] e2, inc_x_n, inc_y_n;
	logic               xmove, ymove;
	logic signed [8:0]  step_x_n;
	logic [8:0]         mag_x;
	logic               vgt;
	logic               cord_start, cord_done;
	logic [31:0]        z_oct;

	logic               xneg, yneg, an, bn, pt_last;
	logic signed [11:0] ox, oy;
	logic [31:0]        th, bang;
	logic signed [11:0] pt_x;
	logic signed [12:0] pt_ysum;

	assign slot_free = !ov_q || out_ch.ready;
	assign out_fire  = slot_free && (state_q == ST_EMIT || state_q == ST_FIN);
	assign cmd_ready = (state_q == ST_IDLE);

	// walk step
	assign e2       = err_q <<< 1;
	assign xmove    = (e2 >= inc_x_q);
	assign ymove    = (e2 <= inc_y_q);
	assign inc_x_n  = xmove ? inc_x_q + 40'({rv2_q, 1'b0}) : inc_x_q;
	assign inc_y_n  = ymove ? inc_y_q + 40'({rh2_q, 1'b0}) : inc_y_q;
	assign step_x_n = step_x_q + 9'(xmove);

	assign mag_x      = px_q[8] ? 9'(-px_q) : 9'(px_q);
	assign vgt        = (v_q > u_q);
	assign cord_start = (state_q == ST_START);

	acelo_angle u_angle (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cord_start),
		.big      (vgt ? v_q : u_q),
		.small_in (vgt ? u_q : v_q),
		.done     (cord_done),
		.z_oct    (z_oct)
	);

	// point k of this step
	always_comb begin
		xneg    = tail_q ? 1'b0 : ~(k_q[0] ^ k_q[1]);
		yneg    = tail_q ? k_q[0] : k_q[1];
		pt_last = tail_q ? k_q[0] : (k_q == 2'd3);
		ox      = xneg ? -12'(px_q) : 12'(px_q);
		oy      = yneg ? -12'({1'b0, py_q}) : 12'({1'b0, py_q});
		an      = oy[11] && (v_q != 16'd0);
		bn      = ox[11] && (u_q != 16'd0);
		if (!bn && !an) th = t_q;
		else if (bn && !an) th = HALF_TURN - t_q;
		else if (bn) th = HALF_TURN + t_q;
		else th = 32'd0 - t_q;
		bang    = th >> (32 - ANGLE_BITS);
		pt_x    = 12'(cen_x_q) + ox;
		pt_ysum = 13'(cen_y_q) + 13'(oy);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL: begin
				u_q <= 16'(mag_x * rv_q);
				v_q <= 16'(py_q * rh_q);
			end
			ST_START: vgt_q <= vgt;
			// zero vector has angle 0
			ST_CORD: t_q <= (u_q == 16'd0 && v_q == 16'd0) ? 32'd0 :
				(vgt_q ? QUARTER_TURN - z_oct : z_oct);
			default: ;
		endcase
		if (state_q == ST_IDLE && cmd_valid) begin
			if (cmd.begin_f) begin
				cen_x_q <= cmd.center_x;
				cen_y_q <= cmd.center_y;
				rh_q    <= cmd.rad_h;
				rv_q    <= cmd.rad_v_half;
				sweep_q <= cmd.sweep;
				rv2_q   <= cmd.rad_v_half * cmd.rad_v_half;
				rh2_q   <= cmd.rad_h * cmd.rad_h;
			end else if (phase_q == PH_MAIN) begin
				px_q   <= step_x_q;
				py_q   <= step_y_q;
				tail_q <= 1'b0;
			end else begin
				px_q   <= 9'sd0;
				py_q   <= step_y_q + 8'd1;
				tail_q <= 1'b1;
			end
		end
		if (state_q == ST_EMIT && slot_free) begin
			drawn_q <= (bang <= {15'b0, sweep_q});
			ox_q    <= pt_x;
			oy_q    <= {pt_ysum[11:0], 1'b0};
			last_q  <= pt_last;
			fin_q   <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			drawn_q <= 1'b0;
			ox_q    <= 12'sd0;
			oy_q    <= 13'sd0;
			last_q  <= 1'b1;
			fin_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_IDLE;
			step_x_q <= 9'sd0;
			step_y_q <= 8'd0;
			inc_x_q  <= 40'sd0;
			inc_y_q  <= 40'sd0;
			err_q    <= 40'sd0;
			k_q      <= 2'd0;
			ov_q     <= 1'b0;
		end else begin
			ov_q <= out_fire || (ov_q && !out_ch.ready);
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.begin_f) begin
							step_x_q <= -9'(cmd.rad_h);
							step_y_q <= 8'd0;
							phase_q  <= PH_MAIN;
							state_q  <= ST_INIT1;
						end else if (phase_q == PH_MAIN) begin
							step_x_q <= step_x_n;
							inc_x_q  <= inc_x_n;
							inc_y_q  <= inc_y_n;
							err_q    <= err_q + (xmove ? inc_x_n : 40'sd0)
								+ (ymove ? inc_y_n : 40'sd0);
							if (ymove) step_y_q <= step_y_q + 8'd1;
							if (step_x_n > 9'sd0) phase_q <= PH_TAIL;
							state_q <= ST_MUL;
						end else if (phase_q == PH_TAIL && step_y_q < {1'b0, rv_q}) begin
							step_y_q <= step_y_q + 8'd1;
							state_q  <= ST_MUL;
						end else begin
							phase_q <= PH_IDLE;
							state_q <= ST_FIN;
						end
					end
				end
				ST_INIT1: begin
					inc_x_q <= 40'((11'sd1 - 11'({rh_q, 1'b0})) * $signed({1'b0, rv2_q}));
					inc_y_q <= 40'({24'b0, rh2_q});
					state_q <= ST_INIT2;
				end
				ST_INIT2: begin
					err_q   <= inc_x_q + inc_y_q;
					state_q <= ST_IDLE;
				end
				ST_MUL: state_q <= ST_START;
				ST_START: state_q <= ST_CORD;
				ST_CORD: begin
					if (cord_done) begin
						k_q     <= 2'd0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						k_q <= k_q + 2'd1;
						if (pt_last) state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid    = ov_q;
	assign out_ch.drawn    = drawn_q;
	assign out_ch.out_x    = ox_q;
	assign out_ch.out_y    = oy_q;
	assign out_ch.last     = last_q;
	assign out_ch.finished = fin_q;
endmodule

// File: src/angle_clipped_ellipse_outline.sv
// Top level of the sector-clipped ellipse outline stepper.
// Usage:
//  in_ch carries commands. action 0 begins a new ellipse (centre, radii, sweep) and
//  gives no output; action 1 advances the walk by one step.
//  out_ch carries points: four mirrored points per main-walk step, two per tail
//  step, with last set on the final one; after the shape ends an advance gives a
//  single transfer with finished and last set.
//  Each point's drawn flag compares its binary angle against the sweep.
// Structure:
//  A two-entry command queue decouples intake from the walker.
//  An advance first forms the step's products, then one arctangent run (30 rotation
//  steps, two per cycle) on the shared angle unit serves all mirrored points of
//  the step before they are emitted.
// Reset clears the walk to idle; an advance then reports finished.
// When the receiver stalls, the output register holds its transfer and the walker
// waits; the command queue keeps taking commands until it is full.
module angle_clipped_ellipse_outline #(
	parameter int MAX_RADIUS = 255,
	parameter int ANGLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	acelo_in_if.sink    in_ch,
	acelo_out_if.source out_ch
);
	import acelo_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	acelo_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready)
	);

	acelo_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_ready (cmd_ready),
		.out_ch    (out_ch)
	);
endmodule
